// ----- rtl/core/sphere_fit_moment_accumulator_assert.svh -----
// Assertion macros for the sphere-fit moment accumulator.
`ifndef SPHERE_FIT_MOMENT_ACCUMULATOR_ASSERT_SVH
`define SPHERE_FIT_MOMENT_ACCUMULATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFMA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SFMA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/sfma_pkg.sv -----
// Package with types, constants and the term schedule of the moment accumulator.
`timescale 1ns / 1ps
`default_nettype none
package sfma_pkg;

   localparam int SFMA_SAMPLE_BITS = 16;
   localparam int AXIS_W = 16;
   localparam int SUM_W = 64;
   localparam int SQUARE_W = 32;
   localparam int OPERAND_W = 33;
   localparam int COUNT_W = 32;
   localparam int NUM_SUMS = 27;
   localparam int SUM_AW = 5;
   localparam int STEP_W = 5;
   localparam int SQUARE_STEPS = 3;
   localparam int LAST_STEP = SQUARE_STEPS + NUM_SUMS - 1;

   localparam logic signed [AXIS_W-1:0] MIN_RESET = 16'sh7fff;
   localparam logic signed [AXIS_W-1:0] MAX_RESET = 16'sh8000;
   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   localparam logic [1:0] CMD_ACCUMULATE = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;

   localparam logic [5:0] IDX_COUNT = 6'd0;
   localparam logic [5:0] IDX_MIN_X = 6'd1;
   localparam logic [5:0] IDX_MAX_X = 6'd4;
   localparam logic [5:0] IDX_SUM_FIRST = 6'd7;
   localparam logic [5:0] IDX_SUM_LAST = 6'd33;

   typedef enum logic [1:0] {
      OPD_ONE,
      OPD_SAMPLE,
      OPD_SQUARE
   } opd_kind_type;

   typedef struct packed {
      opd_kind_type kind_a;
      logic [1:0]   axis_a;
      opd_kind_type kind_b;
      logic [1:0]   axis_b;
   } step_ops_type;

   typedef struct packed {
      logic              load_sample;
      logic              clear;
      logic              read_issue;
      logic              issue;
      logic [STEP_W-1:0] step;
      logic              respond;
   } sfma_cmd_type;

   typedef struct packed {
      logic rsp_free;
   } sfma_status_type;

   // Upper-triangle pair order: xx, xy, yy, xz, yz, zz.
   function automatic logic [3:0] tri_pair(input logic [2:0] p);
      logic [3:0] r;
      unique case (p)
         3'd0: r = {2'd0, 2'd0};
         3'd1: r = {2'd0, 2'd1};
         3'd2: r = {2'd1, 2'd1};
         3'd3: r = {2'd0, 2'd2};
         3'd4: r = {2'd1, 2'd2};
         3'd5: r = {2'd2, 2'd2};
         default: r = {2'd0, 2'd0};
      endcase
      return r;
   endfunction

   // Steps 0-2 form the squares; each later step forms the term of one sum.
   function automatic step_ops_type step_ops(input logic [STEP_W-1:0] step);
      step_ops_type r;
      logic [STEP_W-1:0] k;
      logic [STEP_W-1:0] m;
      logic [3:0] pr;
      logic [1:0] ai;
      k = step - STEP_W'(SQUARE_STEPS);
      m = '0;
      pr = '0;
      ai = '0;
      r = '{kind_a: OPD_ONE, axis_a: 2'd0, kind_b: OPD_ONE, axis_b: 2'd0};
      if (step < STEP_W'(SQUARE_STEPS)) begin
         r = '{OPD_SAMPLE, step[1:0], OPD_SAMPLE, step[1:0]};
      end else if (k < 5'd3) begin
         r = '{OPD_SAMPLE, k[1:0], OPD_ONE, 2'd0};
      end else if (k < 5'd6) begin
         m = k - 5'd3;
         r = '{OPD_SAMPLE, m[1:0], OPD_SAMPLE, m[1:0]};
      end else if (k < 5'd12) begin
         m = k - 5'd6;
         pr = tri_pair(m[2:0]);
         r = '{OPD_SAMPLE, pr[3:2], OPD_SAMPLE, pr[1:0]};
      end else if (k < 5'd21) begin
         m = k - 5'd12;
         ai = (m >= 5'd6) ? 2'd2 : ((m >= 5'd3) ? 2'd1 : 2'd0);
         m = m - 5'(3 * ai);
         r = '{OPD_SQUARE, ai, OPD_SAMPLE, m[1:0]};
      end else begin
         m = k - 5'd21;
         pr = tri_pair(m[2:0]);
         r = '{OPD_SQUARE, pr[3:2], OPD_SQUARE, pr[1:0]};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/sfma_if.sv -----
// Request and response channel interfaces of the moment accumulator.
`timescale 1ns / 1ps
`default_nettype none
interface sfma_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        command;
   logic signed [15:0] sample_x;
   logic signed [15:0] sample_y;
   logic signed [15:0] sample_z;
   logic [5:0]        read_index;
   modport source (output valid, command, sample_x, sample_y, sample_z, read_index,
                   input ready);
   modport sink (input valid, command, sample_x, sample_y, sample_z, read_index,
                 output ready);
endinterface

interface sfma_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] stat_value;
   logic               saturated;
   modport source (output valid, stat_value, saturated, input ready);
   modport sink (input valid, stat_value, saturated, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/sphere_fit_moment_accumulator.sv -----
// Sphere-fit moment accumulator: three-axis running moments with saturation.
// An accumulate beat occupies the block through its steps: one multiplier shared by every
// product forms the three squares and then one of the 27 sum terms per cycle, each added
// into a sum memory with one read and one write port, plus a drain state that writes back
// the last term. A clear beat leaves the block ready for the next beat; a read beat passes
// through a respond state, where it stays while the previous response beat is still held.
`timescale 1ns / 1ps
`default_nettype none
`include "sphere_fit_moment_accumulator_assert.svh"
module sphere_fit_moment_accumulator
   import sfma_pkg::*;
#(
   parameter int SAMPLE_BITS = SFMA_SAMPLE_BITS
) (
   input  wire logic  clock,
   input  wire logic  reset,
   sfma_req_if.sink   req_ch,
   sfma_rsp_if.source rsp_ch
);

   sfma_cmd_type    dp_cmd;
   sfma_status_type dp_status;
   logic            req_ready;

   assign req_ch.ready = req_ready;

   sfma_controller u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_command (req_ch.command),
      .req_ready   (req_ready),
      .cmd         (dp_cmd),
      .status      (dp_status)
   );

   sfma_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (dp_cmd),
      .status     (dp_status),
      .sample_x   (req_ch.sample_x),
      .sample_y   (req_ch.sample_y),
      .sample_z   (req_ch.sample_z),
      .read_index (req_ch.read_index),
      .rsp_ch     (rsp_ch)
   );

   `SFMA_ASSERT_SAME(a_respond_free, clock, reset, dp_cmd.respond, dp_status.rsp_free, "response loaded over a held beat")
   `SFMA_ASSERT_NEXT(a_read_busy, clock, reset, req_ch.valid && req_ready && req_ch.command == CMD_READ, !req_ready, "read beat did not block the next request")
   `SFMA_ASSERT_NEXT(a_acc_busy, clock, reset, req_ch.valid && req_ready && req_ch.command == CMD_ACCUMULATE, dp_cmd.issue && !req_ready, "accumulate did not start its steps")

endmodule
`default_nettype wire

// ----- rtl/core/sfma_datapath.sv -----
// Datapath: sample registers, shared multiplier, saturating adder and sum memory.
`timescale 1ns / 1ps
`default_nettype none
module sfma_datapath
   import sfma_pkg::*;
#(
   parameter int SAMPLE_BITS = SFMA_SAMPLE_BITS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire sfma_cmd_type       cmd,
   output sfma_status_type         status,
   input  wire logic signed [15:0] sample_x,
   input  wire logic signed [15:0] sample_y,
   input  wire logic signed [15:0] sample_z,
   input  wire logic [5:0]         read_index,
   sfma_rsp_if.source              rsp_ch
);

   localparam int SHIFT = AXIS_W - SAMPLE_BITS;

   function automatic logic signed [AXIS_W-1:0] take(input logic signed [AXIS_W-1:0] raw);
      logic signed [AXIS_W-1:0] t;
      t = raw <<< SHIFT;
      return t >>> SHIFT;
   endfunction

   logic signed [AXIS_W-1:0] s_in [3];
   logic signed [AXIS_W-1:0] s_ff [3];
   logic [SQUARE_W-1:0]      sq_ff [3];
   logic signed [AXIS_W-1:0] min_ff [3];
   logic signed [AXIS_W-1:0] max_ff [3];
   logic [COUNT_W-1:0]       count_ff;
   logic                     flag_ff;

   logic [SUM_W-1:0]         mem [NUM_SUMS];
   logic [NUM_SUMS-1:0]      valid_ff;
   logic [SUM_W-1:0]         rd_ff;
   logic                     rd_valid_ff;
   logic [SUM_AW-1:0]        rd_addr;

   logic                     b_valid_ff;
   logic [STEP_W-1:0]        b_step_ff;
   logic signed [SUM_W-1:0]  prod_ff;

   step_ops_type             ops;
   logic signed [OPERAND_W-1:0] opd_a;
   logic signed [OPERAND_W-1:0] opd_b;
   logic signed [2*OPERAND_W-1:0] prod_full;

   logic [SUM_AW-1:0]        b_addr;
   logic signed [SUM_W-1:0]  acc_a;
   logic signed [SUM_W-1:0]  acc_sum;
   logic                     acc_ovf;
   logic signed [SUM_W-1:0]  acc_res;

   logic [5:0]               idx_ff;
   logic [5:0]               idx_off;
   logic                     rsp_valid_ff;
   logic signed [SUM_W-1:0]  stat_ff;
   logic                     sat_ff;
   logic signed [SUM_W-1:0]  stat_in;

   function automatic logic signed [OPERAND_W-1:0] pick(
      input opd_kind_type kind, input logic [1:0] axis,
      input logic signed [AXIS_W-1:0] s [3], input logic [SQUARE_W-1:0] sq [3]);
      logic signed [OPERAND_W-1:0] r;
      unique case (kind)
         OPD_SAMPLE: r = OPERAND_W'(s[axis]);
         OPD_SQUARE: r = $signed({1'b0, sq[axis]});
         default:    r = OPERAND_W'(1);
      endcase
      return r;
   endfunction

   assign s_in[0] = take(sample_x);
   assign s_in[1] = take(sample_y);
   assign s_in[2] = take(sample_z);

   assign ops = step_ops(cmd.step);
   assign opd_a = pick(ops.kind_a, ops.axis_a, s_ff, sq_ff);
   assign opd_b = pick(ops.kind_b, ops.axis_b, s_ff, sq_ff);
   assign prod_full = (2*OPERAND_W)'(opd_a) * (2*OPERAND_W)'(opd_b);

   assign rd_addr = cmd.read_issue ? SUM_AW'(read_index - IDX_SUM_FIRST)
                                   : SUM_AW'(cmd.step - STEP_W'(SQUARE_STEPS));

   assign b_addr = SUM_AW'(b_step_ff - STEP_W'(SQUARE_STEPS));
   assign acc_a = rd_valid_ff ? $signed(rd_ff) : '0;
   assign acc_sum = acc_a + prod_ff;
   assign acc_ovf = (acc_a[SUM_W-1] == prod_ff[SUM_W-1]) &&
                    (acc_sum[SUM_W-1] != acc_a[SUM_W-1]);
   assign acc_res = acc_ovf ? (prod_ff[SUM_W-1] ? SUM_MIN : SUM_MAX) : acc_sum;

   assign idx_off = idx_ff - IDX_MIN_X;

   always_comb begin
      priority if (idx_ff == IDX_COUNT) begin
         stat_in = SUM_W'(count_ff);
      end else if (idx_ff < IDX_MAX_X) begin
         stat_in = SUM_W'(min_ff[idx_off[1:0]]);
      end else if (idx_ff < IDX_SUM_FIRST) begin
         stat_in = SUM_W'(max_ff[2'(idx_ff - IDX_MAX_X)]);
      end else if (idx_ff <= IDX_SUM_LAST) begin
         stat_in = acc_a;
      end else begin
         stat_in = '0;
      end
   end

   assign status.rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.stat_value = stat_ff;
   assign rsp_ch.saturated = sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         flag_ff <= 1'b0;
         valid_ff <= '0;
         b_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            min_ff[i] <= MIN_RESET;
            max_ff[i] <= MAX_RESET;
         end
      end else begin
         b_valid_ff <= cmd.issue;
         if (cmd.clear) begin
            count_ff <= '0;
            flag_ff <= 1'b0;
            valid_ff <= '0;
            for (int i = 0; i < 3; i++) begin
               min_ff[i] <= MIN_RESET;
               max_ff[i] <= MAX_RESET;
            end
         end else if (cmd.load_sample) begin
            if (count_ff == '1) begin
               flag_ff <= 1'b1;
            end else begin
               count_ff <= count_ff + 1'b1;
            end
            for (int i = 0; i < 3; i++) begin
               if (s_in[i] < min_ff[i]) min_ff[i] <= s_in[i];
               if (s_in[i] > max_ff[i]) max_ff[i] <= s_in[i];
            end
         end else if (b_valid_ff && b_step_ff >= STEP_W'(SQUARE_STEPS)) begin
            valid_ff[b_addr] <= 1'b1;
            if (acc_ovf) flag_ff <= 1'b1;
         end
         if (cmd.respond) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_sample) begin
         for (int i = 0; i < 3; i++) s_ff[i] <= s_in[i];
      end
      if (cmd.read_issue) idx_ff <= read_index;
      if (cmd.issue || cmd.read_issue) begin
         rd_ff <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
      if (cmd.issue) begin
         prod_ff <= prod_full[SUM_W-1:0];
         b_step_ff <= cmd.step;
      end
      if (b_valid_ff) begin
         if (b_step_ff < STEP_W'(SQUARE_STEPS)) begin
            sq_ff[b_step_ff[1:0]] <= prod_ff[SQUARE_W-1:0];
         end else begin
            mem[b_addr] <= acc_res;
         end
      end
      if (cmd.respond) begin
         stat_ff <= stat_in;
         sat_ff <= flag_ff;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/sfma_controller.sv -----
// Controller: sequences the accumulate steps, clears and reads.
`timescale 1ns / 1ps
`default_nettype none
module sfma_controller
   import sfma_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic [1:0]      req_command,
   output logic                 req_ready,
   output sfma_cmd_type         cmd,
   input  wire sfma_status_type status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACCUMULATE,
      ST_DRAIN,
      ST_RESPOND
   } state_type;

   state_type         state_ff;
   logic [STEP_W-1:0] step_ff;
   logic              accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept = req_valid && req_ready;

   always_comb begin
      cmd.load_sample = accept && (req_command == CMD_ACCUMULATE);
      cmd.clear = accept && (req_command == CMD_CLEAR);
      cmd.read_issue = accept && (req_command == CMD_READ);
      cmd.issue = (state_ff == ST_ACCUMULATE);
      cmd.step = step_ff;
      cmd.respond = (state_ff == ST_RESPOND) && status.rsp_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               step_ff <= '0;
               if (cmd.load_sample) state_ff <= ST_ACCUMULATE;
               else if (cmd.read_issue) state_ff <= ST_RESPOND;
            end
            ST_ACCUMULATE: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_W'(LAST_STEP)) state_ff <= ST_DRAIN;
            end
            ST_DRAIN: begin
               state_ff <= ST_IDLE;
            end
            ST_RESPOND: begin
               if (status.rsp_free) state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// ----- test/sfma_tb_pkg.sv -----
// Package with the scoreboard class that predicts the moment accumulator responses.
`timescale 1ns / 1ps
package sfma_tb_pkg;
   import sfma_pkg::*;

   typedef struct {
      logic signed [63:0] value;
      logic               sat;
   } stat_reply_type;

   class moment_scoreboard;
      logic [31:0]        count;
      logic signed [15:0] axis_min [3];
      logic signed [15:0] axis_max [3];
      logic signed [63:0] sums [27];
      logic               sat_flag;
      stat_reply_type     pending_replies [$];
      int                 errors;

      function new();
         errors = 0;
         clear_stats();
      endfunction

      function void clear_stats();
         count = '0;
         sat_flag = 1'b0;
         for (int k = 0; k < 3; k++) begin
            axis_min[k] = MIN_RESET;
            axis_max[k] = MAX_RESET;
         end
         for (int k = 0; k < 27; k++) sums[k] = '0;
      endfunction

      function void add_term(int slot, logic signed [127:0] term);
         logic signed [127:0] total;
         total = 128'(sums[slot]) + term;
         if (total > 128'(SUM_MAX)) begin
            sums[slot] = SUM_MAX;
            sat_flag = 1'b1;
         end else if (total < 128'(SUM_MIN)) begin
            sums[slot] = SUM_MIN;
            sat_flag = 1'b1;
         end else begin
            sums[slot] = total[63:0];
         end
      endfunction

      function void fold_sample(logic signed [15:0] s [3]);
         logic signed [127:0] v [3];
         logic signed [127:0] sq [3];
         int t;
         if (count == 32'hffff_ffff) sat_flag = 1'b1;
         else count = count + 1;
         for (int i = 0; i < 3; i++) begin
            v[i] = s[i];
            sq[i] = v[i] * v[i];
         end
         for (int i = 0; i < 3; i++) begin
            if (s[i] < axis_min[i]) axis_min[i] = s[i];
            if (s[i] > axis_max[i]) axis_max[i] = s[i];
            add_term(i, v[i]);
            add_term(3 + i, sq[i]);
            for (int j = 0; j < 3; j++) begin
               add_term(12 + 3 * i + j, sq[i] * v[j]);
               if (i <= j) begin
                  t = (j * (j + 1)) / 2 + i;
                  add_term(6 + t, v[i] * v[j]);
                  add_term(21 + t, sq[i] * sq[j]);
               end
            end
         end
      endfunction

      function void note_request(logic [1:0] cmd, logic signed [15:0] x,
                                 logic signed [15:0] y, logic signed [15:0] z,
                                 logic [5:0] idx);
         logic signed [15:0] s [3];
         stat_reply_type r;
         if (cmd == CMD_ACCUMULATE) begin
            s[0] = x;
            s[1] = y;
            s[2] = z;
            fold_sample(s);
         end else if (cmd == CMD_CLEAR) begin
            clear_stats();
         end else if (cmd == CMD_READ) begin
            if (idx == IDX_COUNT) r.value = {32'd0, count};
            else if (idx < IDX_MAX_X) r.value = 64'(axis_min[idx - IDX_MIN_X]);
            else if (idx < IDX_SUM_FIRST) r.value = 64'(axis_max[idx - IDX_MAX_X]);
            else if (idx <= IDX_SUM_LAST) r.value = sums[idx - IDX_SUM_FIRST];
            else r.value = '0;
            r.sat = sat_flag;
            pending_replies.push_back(r);
         end
      endfunction

      function void check_reply(logic signed [63:0] value, logic sat);
         stat_reply_type r;
         if (pending_replies.size() == 0) begin
            $display("%0t: unexpected response beat, value %0d saturated %0b",
                     $time, value, sat);
            errors++;
            return;
         end
         r = pending_replies.pop_front();
         if (value !== r.value) begin
            $display("%0t: stat_value expected %0d actual %0d", $time, r.value, value);
            errors++;
         end
         if (sat !== r.sat) begin
            $display("%0t: saturated expected %0b actual %0b", $time, r.sat, sat);
            errors++;
         end
      endfunction
   endclass
endpackage

// ----- test/testbench.sv -----
// Testbench top: drives random and directed beats into the moment accumulator.
`timescale 1ns / 1ps
module testbench;
   import sfma_pkg::*;
   import sfma_tb_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   send_idle_pct = 0;
   int   stall_pct = 0;
   longint cycles = 0;
   moment_scoreboard board = new();

   sfma_req_if req_ch();
   sfma_rsp_if rsp_ch();

   sphere_fit_moment_accumulator dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   always #5 clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.command = CMD_CLEAR;
      req_ch.sample_x = '0;
      req_ch.sample_y = '0;
      req_ch.sample_z = '0;
      req_ch.read_index = '0;
      rsp_ch.ready = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3_000_000) begin
         $display("** sphere_fit_moment_accumulator: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.check_reply(rsp_ch.stat_value, rsp_ch.saturated);
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic send_beat(logic [1:0] cmd, logic signed [15:0] x, logic signed [15:0] y,
                            logic signed [15:0] z, logic [5:0] idx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.command <= cmd;
      req_ch.sample_x <= x;
      req_ch.sample_y <= y;
      req_ch.sample_z <= z;
      req_ch.read_index <= idx;
      do @(posedge clock); while (!req_ch.ready);
      board.note_request(cmd, x, y, z, idx);
   endtask

   task automatic read_all();
      for (int k = 0; k < 34; k++) send_beat(CMD_READ, 16'sd0, 16'sd0, 16'sd0, 6'(k));
   endtask

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(5))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'($urandom_range(16) - 8);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_beat();
      int r;
      r = $urandom_range(99);
      if (r < 60)
         send_beat(CMD_ACCUMULATE, pick_sample(), pick_sample(), pick_sample(), '0);
      else if (r < 63)
         send_beat(CMD_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), 6'($urandom));
      else if (r < 65)
         send_beat(2'd3, 16'($urandom), 16'($urandom), 16'($urandom), 6'($urandom));
      else
         send_beat(CMD_READ, 16'($urandom), 16'($urandom), 16'($urandom),
                   ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(33)));
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_beat(CMD_READ, 16'sd0, 16'sd0, 16'sd0, IDX_COUNT);
      send_beat(CMD_READ, 16'sd0, 16'sd0, 16'sd0, IDX_MIN_X);
      send_beat(CMD_READ, 16'sd0, 16'sd0, 16'sd0, IDX_MAX_X);
      send_beat(CMD_ACCUMULATE, 16'sh7fff, 16'sh8000, 16'sh0001, '0);
      send_beat(CMD_ACCUMULATE, 16'sh8000, 16'sh7fff, 16'shffff, '0);
      send_beat(2'd3, 16'sh1234, 16'sh1234, 16'sh1234, 6'd7);
      send_beat(CMD_READ, 16'sd0, 16'sd0, 16'sd0, 6'd63);
      send_beat(CMD_READ, 16'sd0, 16'sd0, 16'sd0, 6'd34);
      send_beat(CMD_READ, 16'sd0, 16'sd0, 16'sd0, 6'd33);
      send_beat(CMD_READ, 16'sd0, 16'sd0, 16'sd0, 6'd22);
      send_beat(CMD_READ, 16'sd0, 16'sd0, 16'sd0, 6'd3);
      send_beat(CMD_CLEAR, 16'sd0, 16'sd0, 16'sd0, '0);
      send_beat(CMD_READ, 16'sd0, 16'sd0, 16'sd0, 6'd28);
      // Full-scale samples of one sign drive the fourth-power sums into saturation.
      for (int k = 0; k < 12; k++)
         send_beat(CMD_ACCUMULATE, 16'sh8000, 16'sh8000, 16'sh8000, '0);
      read_all();
      send_beat(CMD_CLEAR, 16'sd0, 16'sd0, 16'sd0, '0);
      for (int ph = 0; ph < 5; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? 76 : ((ph == 4) ? 30 : 0);
         stall_pct = (ph == 2 || ph == 3) ? 76 : ((ph == 4) ? 30 : 0);
         for (int k = 0; k < 250; k++) random_beat();
      end
      req_ch.valid <= 1'b0;
      send_idle_pct = 0;
      stall_pct = 0;
      while (board.pending_replies.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (board.errors == 0 && board.pending_replies.size() == 0)
         $display("** sphere_fit_moment_accumulator: PASSED **");
      else
         $display("** sphere_fit_moment_accumulator: FAILED **");
      $finish;
   end
endmodule
